// ===== design/im2col_pkg.sv =====
`default_nettype none

package im2col_pkg;

	// default store dimensions
	localparam int DEF_MAX_CHANNELS = 16;
	localparam int DEF_MAX_HEIGHT   = 64;
	localparam int DEF_MAX_WIDTH    = 64;
	localparam int DEF_MAX_KERNEL   = 16;

	// largest stride the walk honors
	localparam int STRIDE_MAX = 16;

	// field and counter widths
	localparam int PIXEL_W  = 32;
	localparam int CH_W     = 4;
	localparam int POS_W    = 6;
	localparam int SIZE_W   = 7;
	localparam int KSIZE_W  = 5;
	localparam int PAD_W    = 4;
	localparam int STEP_W   = 5;
	localparam int KCNT_W   = 5;
	localparam int OCNT_W   = 8;
	localparam int SRC_W    = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 7;

	// request codes
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_GEN  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_IN_HEIGHT     = 3'd0,
		CFG_IN_WIDTH      = 3'd1,
		CFG_KERNEL_HEIGHT = 3'd2,
		CFG_KERNEL_WIDTH  = 3'd3,
		CFG_PAD_ROWS      = 3'd4,
		CFG_PAD_COLS      = 3'd5,
		CFG_STRIDE_ROWS   = 3'd6,
		CFG_STRIDE_COLS   = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic              cmd;
		logic [CH_W-1:0]    channel;
		logic [POS_W-1:0]   pixel_row;
		logic [POS_W-1:0]   pixel_col;
		logic [PIXEL_W-1:0] pixel_value;
	} req_t;

	typedef struct packed {
		logic [PIXEL_W-1:0] col_value;
		logic               block_last;
		logic               config_error;
	} result_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic write;
		logic calc;
		logic read;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic cfg_err;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== design/im2col_ram.sv =====
`default_nettype none

module im2col_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic             we,
	input  wire logic [AddrW-1:0] addr,
	input  wire logic [WIDTH-1:0] wdata,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en && we) begin
			mem_q[addr] <= wdata;
		end
		if (en && !we) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/im2col_ctrl.sv =====
`default_nettype none

module im2col_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   req_cmd,
	input  wire im2col_pkg::dp_status_t status,
	output im2col_pkg::dp_cmd_t         cmd,
	output logic                        busy,
	output logic                        done
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WRITE = 5'b00010,
		ST_CALC  = 5'b00100,
		ST_READ  = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = (req_cmd == im2col_pkg::CMD_GEN) ? ST_CALC : ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_CALC:  state_d = status.cfg_err ? ST_EMIT : ST_READ;
			ST_READ:  state_d = ST_EMIT;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.write   = (state_q == ST_WRITE);
	assign cmd.calc    = (state_q == ST_CALC);
	assign cmd.read    = (state_q == ST_READ);
	assign busy        = (state_q != ST_IDLE);
	assign done        = (state_q == ST_EMIT);

endmodule

`default_nettype wire

// ===== design/im2col_dp.sv =====
`default_nettype none

module im2col_dp #(
	parameter int MAX_CHANNELS = im2col_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = im2col_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = im2col_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL   = im2col_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire im2col_pkg::dp_cmd_t                   cmd,
	output im2col_pkg::dp_status_t                     status,
	input  wire im2col_pkg::req_t                      req,
	input  wire logic                                  cfg_valid,
	input  wire logic [im2col_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [im2col_pkg::CFG_DATA_W-1:0]     cfg_data,
	output im2col_pkg::result_t                        result
);

	localparam int Depth = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

	function automatic logic [AddrW-1:0] store_addr(
		input logic [im2col_pkg::CH_W-1:0]  ch,
		input logic [im2col_pkg::SRC_W-1:0] row,
		input logic [im2col_pkg::SRC_W-1:0] col
	);
		logic [AddrW-1:0] a;
		a = AddrW'(ch) * AddrW'(MAX_HEIGHT * MAX_WIDTH)
			+ AddrW'(row) * AddrW'(MAX_WIDTH) + AddrW'(col);
		return a;
	endfunction

	// configuration registers
	logic [im2col_pkg::SIZE_W-1:0]   in_height_q, in_width_q;
	logic [im2col_pkg::KSIZE_W-1:0]  kernel_height_q, kernel_width_q;
	logic [im2col_pkg::PAD_W-1:0]    pad_rows_q, pad_cols_q;
	logic [im2col_pkg::STEP_W-1:0]   stride_rows_q, stride_cols_q;

	// walk state
	logic [im2col_pkg::KCNT_W-1:0] kr_q, kc_q;
	logic [im2col_pkg::OCNT_W-1:0] or_q, oc_q;
	logic [im2col_pkg::SRC_W-1:0]  src_row_q, src_col_q;
	logic hit_q, last_q, err_q;

	im2col_pkg::req_t req_q;

	// effective sizes
	logic [im2col_pkg::SIZE_W-1:0]   h, w;
	logic [im2col_pkg::KSIZE_W-1:0]  kh, kw;
	logic [im2col_pkg::STEP_W-1:0]   sr, sc;
	logic [7:0]  ph, pw, span_r, span_c;
	logic        cfg_err;

	logic [13:0] row_prod, col_prod, row_pos, col_pos;
	logic [13:0] row_src, col_src;
	logic        row_in, col_in, ch_ok;
	logic [13:0] or_next_prod, oc_next_prod;
	logic        oc_end, or_end, kc_end, kr_end;

	logic                          wr_ok;
	logic                          ram_en;
	logic [AddrW-1:0]              ram_addr;
	logic [im2col_pkg::PIXEL_W-1:0] ram_rdata;

	always_comb begin
		if (in_height_q == '0) h = 7'd1;
		else if (32'(in_height_q) > 32'(MAX_HEIGHT)) h = 7'(MAX_HEIGHT);
		else h = in_height_q;

		if (in_width_q == '0) w = 7'd1;
		else if (32'(in_width_q) > 32'(MAX_WIDTH)) w = 7'(MAX_WIDTH);
		else w = in_width_q;

		if (kernel_height_q == '0) kh = 5'd1;
		else if (32'(kernel_height_q) > 32'(MAX_KERNEL)) kh = 5'(MAX_KERNEL);
		else kh = kernel_height_q;

		if (kernel_width_q == '0) kw = 5'd1;
		else if (32'(kernel_width_q) > 32'(MAX_KERNEL)) kw = 5'(MAX_KERNEL);
		else kw = kernel_width_q;

		if (stride_rows_q == '0) sr = 5'd1;
		else if (32'(stride_rows_q) > 32'(im2col_pkg::STRIDE_MAX))
			sr = 5'(im2col_pkg::STRIDE_MAX);
		else sr = stride_rows_q;

		if (stride_cols_q == '0) sc = 5'd1;
		else if (32'(stride_cols_q) > 32'(im2col_pkg::STRIDE_MAX))
			sc = 5'(im2col_pkg::STRIDE_MAX);
		else sc = stride_cols_q;
	end

	assign ph      = 8'(h) + {3'b000, pad_rows_q, 1'b0};
	assign pw      = 8'(w) + {3'b000, pad_cols_q, 1'b0};
	assign cfg_err = (8'(kh) > ph) || (8'(kw) > pw);
	assign span_r  = ph - 8'(kh);
	assign span_c  = pw - 8'(kw);

	// source position of the current element
	assign row_prod = 14'(or_q) * 14'(sr);
	assign col_prod = 14'(oc_q) * 14'(sc);
	assign row_pos  = 14'(kr_q) + row_prod;
	assign col_pos  = 14'(kc_q) + col_prod;
	assign row_src  = row_pos - 14'(pad_rows_q);
	assign col_src  = col_pos - 14'(pad_cols_q);
	assign row_in   = (row_pos >= 14'(pad_rows_q)) && (row_src < 14'(h));
	assign col_in   = (col_pos >= 14'(pad_cols_q)) && (col_src < 14'(w));
	assign ch_ok    = 32'(req_q.channel) < 32'(MAX_CHANNELS);

	// (n + 1) * stride > span is the same as n + 1 >= output count
	assign or_next_prod = 14'(9'(or_q) + 9'd1) * 14'(sr);
	assign oc_next_prod = 14'(9'(oc_q) + 9'd1) * 14'(sc);
	assign or_end = or_next_prod > 14'(span_r);
	assign oc_end = oc_next_prod > 14'(span_c);
	assign kc_end = (6'(kc_q) + 6'd1) >= 6'(kw);
	assign kr_end = (6'(kr_q) + 6'd1) >= 6'(kh);

	assign status.cfg_err = cfg_err;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_height_q     <= 7'd1;
			in_width_q      <= 7'd1;
			kernel_height_q <= 5'd1;
			kernel_width_q  <= 5'd1;
			pad_rows_q      <= '0;
			pad_cols_q      <= '0;
			stride_rows_q   <= 5'd1;
			stride_cols_q   <= 5'd1;
		end else if (cfg_valid) begin
			unique case (im2col_pkg::cfg_reg_t'(cfg_index))
				im2col_pkg::CFG_IN_HEIGHT:     in_height_q     <= cfg_data;
				im2col_pkg::CFG_IN_WIDTH:      in_width_q      <= cfg_data;
				im2col_pkg::CFG_KERNEL_HEIGHT: kernel_height_q <= cfg_data[4:0];
				im2col_pkg::CFG_KERNEL_WIDTH:  kernel_width_q  <= cfg_data[4:0];
				im2col_pkg::CFG_PAD_ROWS:      pad_rows_q      <= cfg_data[3:0];
				im2col_pkg::CFG_PAD_COLS:      pad_cols_q      <= cfg_data[3:0];
				im2col_pkg::CFG_STRIDE_ROWS:   stride_rows_q   <= cfg_data[4:0];
				im2col_pkg::CFG_STRIDE_COLS:   stride_cols_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q      <= '0;
			kc_q      <= '0;
			or_q      <= '0;
			oc_q      <= '0;
			src_row_q <= '0;
			src_col_q <= '0;
			hit_q     <= 1'b0;
			last_q    <= 1'b0;
			err_q     <= 1'b0;
		end else if (cmd.calc) begin
			if (cfg_err) begin
				// restart the walk, answer with a flagged zero
				kr_q      <= '0;
				kc_q      <= '0;
				or_q      <= '0;
				oc_q      <= '0;
				src_row_q <= '0;
				src_col_q <= '0;
				hit_q     <= 1'b0;
				last_q    <= 1'b1;
				err_q     <= 1'b1;
			end else begin
				src_row_q <= row_src[im2col_pkg::SRC_W-1:0];
				src_col_q <= col_src[im2col_pkg::SRC_W-1:0];
				hit_q     <= ch_ok && row_in && col_in;
				last_q    <= oc_end && or_end && kc_end && kr_end;
				err_q     <= 1'b0;
				if (!oc_end) begin
					oc_q <= oc_q + 8'd1;
				end else begin
					oc_q <= '0;
					if (!or_end) begin
						or_q <= or_q + 8'd1;
					end else begin
						or_q <= '0;
						if (!kc_end) begin
							kc_q <= kc_q + 5'd1;
						end else begin
							kc_q <= '0;
							kr_q <= kr_end ? '0 : kr_q + 5'd1;
						end
					end
				end
			end
		end
	end

	// drop loads that fall outside the store
	assign wr_ok = (32'(req_q.channel) < 32'(MAX_CHANNELS))
		&& (32'(req_q.pixel_row) < 32'(MAX_HEIGHT))
		&& (32'(req_q.pixel_col) < 32'(MAX_WIDTH));

	assign ram_en   = (cmd.write && wr_ok) || cmd.read;
	assign ram_addr = cmd.write
		? store_addr(req_q.channel, 9'(req_q.pixel_row), 9'(req_q.pixel_col))
		: store_addr(req_q.channel, src_row_q, src_col_q);

	im2col_ram #(
		.WIDTH(im2col_pkg::PIXEL_W),
		.DEPTH(Depth)
	) u_store (
		.clk  (clk),
		.en   (ram_en),
		.we   (cmd.write),
		.addr (ram_addr),
		.wdata(req_q.pixel_value),
		.rdata(ram_rdata)
	);

	assign result.col_value    = hit_q ? ram_rdata : '0;
	assign result.block_last   = last_q;
	assign result.config_error = err_q;

endmodule

`default_nettype wire

// ===== design/im2col_patch_generator_unit.sv =====
`default_nettype none

// im2col patch generator: unfolds a stored multi-channel image into the
// column matrix of a convolution, one element per generate request.
//
// Request channel: raise start with req; the request is taken at an edge
// where start is high and busy is low. A load request (cmd 0) writes
// pixel_value into the image store at channel/row/column and gives no
// result. A generate request (cmd 1) gives the next element of the
// walk, which all channels share, read from req's channel: done pulses
// for one cycle with result after the calc, store read and emit steps
// (after calc and emit alone when the kernel does not fit the padded
// image). One request is in flight at a time; no new request is taken
// until the last one's write or emit step is through.
// Result channel: done marks result for exactly one cycle; the receiver
// cannot stall and must take it then.
// Configuration channel: cfg_ready is always high; write the eight
// geometry registers only while busy is low.
// Reset (arst_n low) restores unit sizes and strides, zero padding and
// the start of the walk. The image store is not cleared: load a pixel
// before any walk reads it.
module im2col_patch_generator_unit #(
	parameter int MAX_CHANNELS = im2col_pkg::DEF_MAX_CHANNELS,
	parameter int MAX_HEIGHT   = im2col_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH    = im2col_pkg::DEF_MAX_WIDTH,
	parameter int MAX_KERNEL   = im2col_pkg::DEF_MAX_KERNEL
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire im2col_pkg::req_t                  req,
	output logic                                   done,
	output im2col_pkg::result_t                    result,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [im2col_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [im2col_pkg::CFG_DATA_W-1:0] cfg_data
);

	im2col_pkg::dp_cmd_t    dp_cmd;
	im2col_pkg::dp_status_t dp_status;

	// take configuration writes in any cycle
	assign cfg_ready = 1'b1;

	// sequence each request: capture, then write, or calc / read / emit (no read on a config error)
	im2col_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req_cmd(req.cmd),
		.status (dp_status),
		.cmd    (dp_cmd),
		.busy   (busy),
		.done   (done)
	);

	// hold geometry, walk counters and the image store
	im2col_dp #(
		.MAX_CHANNELS(MAX_CHANNELS),
		.MAX_HEIGHT  (MAX_HEIGHT),
		.MAX_WIDTH   (MAX_WIDTH),
		.MAX_KERNEL  (MAX_KERNEL)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (dp_cmd),
		.status   (dp_status),
		.req      (req),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.result   (result)
	);

`ifndef ASSERT_OFF
	// a flagged configuration error carries a zero that closes the block
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.config_error |-> result.block_last && result.col_value == '0)
		else $error("config error result not a zero closing the block");

	// a load never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.cmd == im2col_pkg::CMD_LOAD |=> !done ##1 !done)
		else $error("result after a load request");

	// every result answers a generate request taken ahead of its calc, read
	// and emit steps, or of calc and emit alone when flagged as a config error
	a_result_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(start && !busy && req.cmd == im2col_pkg::CMD_GEN, 3)
			|| ($past(start && !busy && req.cmd == im2col_pkg::CMD_GEN, 2)
				&& result.config_error)))
		else $error("result without a matching generate request");
`endif

endmodule

`default_nettype wire

// ===== dv/im2col_patch_generator_unit_tb.sv =====
`timescale 1ns / 1ps

// Block-level bench for the im2col patch generator.
// Pixels are loaded into the image store through load requests. Generate
// requests walk the column matrix of one channel. A shadow copy of the
// geometry, the walk counters and the image store predicts every element.
// The checker compares each strobed result with the oldest prediction.
module im2col_patch_generator_unit_tb;
	import im2col_pkg::*;

	localparam int MAX_CH = DEF_MAX_CHANNELS;
	localparam int MAX_H  = DEF_MAX_HEIGHT;
	localparam int MAX_W  = DEF_MAX_WIDTH;
	localparam int MAX_K  = DEF_MAX_KERNEL;
	localparam int STORE_DEPTH = MAX_CH * MAX_H * MAX_W;

	localparam int IDLE_PCT      = 26;   // sender idles in about this share of requests
	localparam int SETTLE_CYCLES = 6;    // a load gives no result, so let it finish
	localparam int DRAIN_CYCLES  = 12;   // tail after the last element
	localparam int STALL_LIMIT   = 1000; // cycles with no handshake of any kind
	localparam int RANDOM_ITEMS  = 320;

	// one predicted element plus the time its request was taken, so that a
	// strobe in the same step as the request can never consume it
	typedef struct {
		result_t elem;
		time     taken_at;
	} elem_exp_t;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  start     = 1'b0;
	logic                  busy;
	req_t                  req       = '0;
	logic                  done;
	result_t               result;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	im2col_patch_generator_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// Shadow geometry registers, at their register widths and reset values.
	logic [SIZE_W-1:0]   geo_h  = 7'd1;
	logic [SIZE_W-1:0]   geo_w  = 7'd1;
	logic [KSIZE_W-1:0]  geo_kh = 5'd1;
	logic [KSIZE_W-1:0]  geo_kw = 5'd1;
	logic [PAD_W-1:0]    geo_pr = 4'd0;
	logic [PAD_W-1:0]    geo_pc = 4'd0;
	logic [STEP_W-1:0]   geo_sr = 5'd1;
	logic [STEP_W-1:0]   geo_sc = 5'd1;

	// Effective geometry, recomputed after each geometry is programmed.
	int eff_h, eff_w, eff_kh, eff_kw, eff_sr, eff_sc, out_h, out_w;
	bit misfit;

	// Walk position, shared by all channels.
	int kr_cnt = 0;
	int kc_cnt = 0;
	int or_cnt = 0;
	int oc_cnt = 0;

	logic [PIXEL_W-1:0] pix_mem  [STORE_DEPTH];
	bit                 pix_seen [STORE_DEPTH];

	elem_exp_t pending_elems[$];

	int  fault_count = 0;
	int  stall_cycles = 0;
	int  n_items = 0, n_loads = 0, n_gens = 0, n_cfg = 0, n_geoms = 0;
	int  n_results = 0, n_lasts = 0, n_misfits = 0;
	bit  no_idle = 1'b0;

	function automatic int clip(input int v, input int lo, input int hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic int pix_addr(input int ch, input int row, input int col);
		return (ch * MAX_H + row) * MAX_W + col;
	endfunction

	// Out-of-range sizes and strides: zero acts as one, large values saturate.
	function automatic void refresh_geom();
		int padded_h, padded_w;
		eff_h  = clip(int'(geo_h), 1, MAX_H);
		eff_w  = clip(int'(geo_w), 1, MAX_W);
		eff_kh = clip(int'(geo_kh), 1, MAX_K);
		eff_kw = clip(int'(geo_kw), 1, MAX_K);
		eff_sr = clip(int'(geo_sr), 1, STRIDE_MAX);
		eff_sc = clip(int'(geo_sc), 1, STRIDE_MAX);
		padded_h = eff_h + 2 * int'(geo_pr);
		padded_w = eff_w + 2 * int'(geo_pc);
		misfit = (eff_kh > padded_h) || (eff_kw > padded_w);
		out_h = misfit ? 1 : (padded_h - eff_kh) / eff_sr + 1;
		out_w = misfit ? 1 : (padded_w - eff_kw) / eff_sc + 1;
	endfunction

	// Source pixel of the current walk position; padding lands outside.
	function automatic void locate(input int ch, output bit in_img, output int addr);
		int srow, scol;
		srow = kr_cnt + or_cnt * eff_sr - int'(geo_pr);
		scol = kc_cnt + oc_cnt * eff_sc - int'(geo_pc);
		in_img = ch < MAX_CH && srow >= 0 && srow < eff_h && scol >= 0 && scol < eff_w;
		addr = in_img ? pix_addr(ch, srow, scol) : 0;
	endfunction

	// Apply one taken request to the shadow state; give the element it yields.
	function automatic void unfold_next(input req_t r, output bit has_elem,
			output result_t elem);
		bit in_img, last;
		int addr;
		elem = '0;
		has_elem = 1'b0;
		if (r.cmd == CMD_LOAD) begin
			if (r.channel < MAX_CH && r.pixel_row < MAX_H && r.pixel_col < MAX_W) begin
				addr = pix_addr(r.channel, r.pixel_row, r.pixel_col);
				pix_mem[addr]  = r.pixel_value;
				pix_seen[addr] = 1'b1;
			end
			return;
		end
		has_elem = 1'b1;
		if (misfit) begin
			// kernel does not fit: lone zero element, flagged, walk starts over
			kr_cnt = 0;
			kc_cnt = 0;
			or_cnt = 0;
			oc_cnt = 0;
			elem.block_last   = 1'b1;
			elem.config_error = 1'b1;
			return;
		end
		locate(r.channel, in_img, addr);
		if (in_img)
			elem.col_value = pix_mem[addr];
		// a counter at or past a shrunken bound counts as being at its end
		last = (oc_cnt + 1 >= out_w) && (or_cnt + 1 >= out_h) &&
			(kc_cnt + 1 >= eff_kw) && (kr_cnt + 1 >= eff_kh);
		if (oc_cnt + 1 < out_w) begin
			oc_cnt++;
		end else begin
			oc_cnt = 0;
			if (or_cnt + 1 < out_h) begin
				or_cnt++;
			end else begin
				or_cnt = 0;
				if (kc_cnt + 1 < eff_kw) begin
					kc_cnt++;
				end else begin
					kc_cnt = 0;
					kr_cnt = (kr_cnt + 1 < eff_kh) ? kr_cnt + 1 : 0;
				end
			end
		end
		elem.block_last = last;
	endfunction

	// Present one request and hold it until taken, then predict it. Start
	// stays high when the next request follows at once; on an idle roll,
	// drop it and wait before sending the next.
	task automatic send_req(input req_t r);
		bit        has_elem;
		result_t   elem;
		elem_exp_t want;
		start <= 1'b1;
		req   <= r;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		unfold_next(r, has_elem, elem);
		if (has_elem) begin
			want.elem     = elem;
			want.taken_at = $time;
			pending_elems = {pending_elems, want};
		end
		if (r.cmd == CMD_GEN)
			n_gens++;
		else
			n_loads++;
		n_items++;
		if (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	task automatic load_px(input int ch, input int row, input int col,
			input logic [PIXEL_W-1:0] val);
		req_t r;
		r.cmd         = CMD_LOAD;
		r.channel     = CH_W'(ch);
		r.pixel_row   = POS_W'(row);
		r.pixel_col   = POS_W'(col);
		r.pixel_value = val;
		send_req(r);
	endtask

	// Generate the next element of a channel. The store is not cleared at
	// reset, so load the source pixel first if the walk is about to read a
	// position that was never written.
	task automatic unfold_req(input int ch);
		req_t r;
		bit   in_img;
		int   addr;
		if (!misfit) begin
			locate(ch, in_img, addr);
			if (in_img && !pix_seen[addr])
				load_px(ch, (addr / MAX_W) % MAX_H, addr % MAX_W, $urandom());
		end
		// position and value fields mean nothing to a generate; fill with noise
		r.cmd         = CMD_GEN;
		r.channel     = CH_W'(ch);
		r.pixel_row   = POS_W'($urandom());
		r.pixel_col   = POS_W'($urandom());
		r.pixel_value = $urandom();
		send_req(r);
	endtask

	// Stop sending and hold until every predicted element has come back.
	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (pending_elems.size() != 0)
			@(posedge clk);
	endtask

	// Loads leave nothing to wait for, so add a pause before touching config.
	task automatic quiesce();
		drain_results();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
	endtask

	// Leaves cfg_valid high; the caller lowers it after the last write.
	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		case (idx)
			CFG_IN_HEIGHT:     geo_h  = val[SIZE_W-1:0];
			CFG_IN_WIDTH:      geo_w  = val[SIZE_W-1:0];
			CFG_KERNEL_HEIGHT: geo_kh = val[KSIZE_W-1:0];
			CFG_KERNEL_WIDTH:  geo_kw = val[KSIZE_W-1:0];
			CFG_PAD_ROWS:      geo_pr = val[PAD_W-1:0];
			CFG_PAD_COLS:      geo_pc = val[PAD_W-1:0];
			CFG_STRIDE_ROWS:   geo_sr = val[STEP_W-1:0];
			CFG_STRIDE_COLS:   geo_sc = val[STEP_W-1:0];
			default: ;
		endcase
		n_cfg++;
	endtask

	task automatic program_geometry(input int h, input int w, input int kh, input int kw,
			input int pr, input int pc, input int sr, input int sc);
		quiesce();
		write_reg(CFG_IN_HEIGHT, CFG_DATA_W'(h));
		write_reg(CFG_IN_WIDTH, CFG_DATA_W'(w));
		write_reg(CFG_KERNEL_HEIGHT, CFG_DATA_W'(kh));
		write_reg(CFG_KERNEL_WIDTH, CFG_DATA_W'(kw));
		write_reg(CFG_PAD_ROWS, CFG_DATA_W'(pr));
		write_reg(CFG_PAD_COLS, CFG_DATA_W'(pc));
		write_reg(CFG_STRIDE_ROWS, CFG_DATA_W'(sr));
		write_reg(CFG_STRIDE_COLS, CFG_DATA_W'(sc));
		cfg_valid <= 1'b0;
		refresh_geom();
		n_geoms++;
	endtask

	function automatic int pick_end(input int lo, input int hi);
		return $urandom_range(0, 1) ? hi : lo;
	endfunction

	// Reset geometry is a 1x1 image with a 1x1 kernel: every element ends a block.
	task automatic test_reset_defaults();
		repeat (3)
			unfold_req(0);
		unfold_req(MAX_CH - 1);
	endtask

	task automatic test_field_extremes();
		load_px(MAX_CH - 1, MAX_H - 1, MAX_W - 1, 32'hFFFF_FFFF);
		load_px(0, 0, 0, 32'h0000_0000);
		load_px(10, 42, 21, 32'h5A5A_A5A5);
		load_px(5, 21, 42, 32'hA5A5_5A5A);
		// largest image, kernel, padding and stride together
		program_geometry(64, 64, 16, 16, 15, 15, 16, 16);
		repeat (4)
			unfold_req(MAX_CH - 1);
		unfold_req(0);
		// kernel taller than the padded image: expect a lone flagged element
		program_geometry(1, 1, 16, 1, 0, 0, 1, 1);
		repeat (2)
			unfold_req(3);
		// kernel wider than the padded image
		program_geometry(2, 2, 1, 5, 0, 1, 1, 1);
		unfold_req(7);
		// raw values outside the legal ranges: zero acts as one, high saturates
		program_geometry(0, 127, 0, 31, 0, 15, 0, 31);
		repeat (3)
			unfold_req(MAX_CH - 1);
		program_geometry(127, 0, 31, 0, 15, 0, 31, 0);
		repeat (2)
			unfold_req(9);
	endtask

	// Run past a whole block twice so block_last lands at the wrap, then
	// reshape while the walk is mid-block.
	task automatic test_whole_block();
		program_geometry(3, 4, 2, 3, 1, 1, 2, 1);
		for (int r = 0; r < 3; r++)
			for (int c = 0; c < 4; c++)
				load_px(5, r, c, $urandom());
		// 2 x 3 kernel positions over a 2 x 4 output grid: 48 per block
		repeat (2 * 48 + 3)
			unfold_req(5);
		program_geometry(6, 6, 4, 4, 2, 2, 1, 1);
		repeat (37)
			unfold_req(6);
		// shrink: counters beyond the new bounds must wrap on the next step
		program_geometry(2, 2, 1, 1, 0, 0, 1, 1);
		repeat (6)
			unfold_req(6);
	endtask

	// Phases of random geometry, mostly small so blocks close often. Half the
	// requests walk one or two channels of the phase, some walk any channel;
	// the rest load pixels inside the configured image or anywhere in the store.
	task automatic test_random_traffic();
		int target, phase, span, ch_a, ch_b, pick;
		target = n_items + RANDOM_ITEMS;
		phase  = 0;
		while (n_items < target) begin
			case ($urandom_range(0, 9))
				0: program_geometry($urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127),
					$urandom_range(0, 127), $urandom_range(0, 127));
				1: program_geometry(pick_end(1, 64), pick_end(1, 64),
					pick_end(1, 16), pick_end(1, 16), pick_end(0, 15),
					pick_end(0, 15), pick_end(1, 16), pick_end(1, 16));
				default: program_geometry($urandom_range(1, 8), $urandom_range(1, 8),
					$urandom_range(1, 5), $urandom_range(1, 5),
					$urandom_range(0, 3), $urandom_range(0, 3),
					$urandom_range(1, 3), $urandom_range(1, 3));
			endcase
			// third phase runs back to back with no idle at all
			no_idle = (phase == 2);
			span = no_idle ? 90 : $urandom_range(20, 60);
			ch_a = $urandom_range(0, MAX_CH - 1);
			ch_b = $urandom_range(0, MAX_CH - 1);
			repeat (span) begin
				pick = $urandom_range(0, 99);
				if (pick < 40)
					unfold_req(ch_a);
				else if (pick < 50)
					unfold_req(ch_b);
				else if (pick < 55)
					unfold_req($urandom_range(0, MAX_CH - 1));
				else if (pick < 80)
					load_px(pick < 70 ? ch_a : ch_b, $urandom_range(0, eff_h - 1),
						$urandom_range(0, eff_w - 1), $urandom());
				else
					load_px($urandom_range(0, MAX_CH - 1), $urandom_range(0, MAX_H - 1),
						$urandom_range(0, MAX_W - 1), $urandom());
				// now and then hold off until every element is back
				if ($urandom_range(0, 39) == 0)
					drain_results();
			end
			no_idle = 1'b0;
			phase++;
		end
	endtask

	initial begin
		refresh_geom();
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_field_extremes();
		test_whole_block();
		test_random_traffic();

		drain_results();
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("covered %0d loads, %0d generates, %0d elements checked", n_loads, n_gens,
			n_results);
		$display("%0d block ends, %0d misfit kernels, %0d register writes in %0d geometries",
			n_lasts, n_misfits, n_cfg, n_geoms);
		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Compare each strobed element with the oldest prediction. Only a
	// request taken at an earlier edge can own it.
	always @(posedge clk) begin : result_check
		elem_exp_t want;
		if (arst_n && done !== 1'b0) begin
			if (pending_elems.size() == 0 || pending_elems[0].taken_at >= $time) begin
				fault_count++;
				$display("%0t: element with none expected: got value %h last %b err %b",
					$time, result.col_value, result.block_last, result.config_error);
			end else begin
				want = pending_elems.pop_front();
				n_results++;
				if (want.elem.block_last)
					n_lasts++;
				if (want.elem.config_error)
					n_misfits++;
				if (result.col_value !== want.elem.col_value) begin
					fault_count++;
					$display("%0t: col_value expected %h got %h", $time,
						want.elem.col_value, result.col_value);
				end
				if (result.block_last !== want.elem.block_last) begin
					fault_count++;
					$display("%0t: block_last expected %b got %b", $time,
						want.elem.block_last, result.block_last);
				end
				if (result.config_error !== want.elem.config_error) begin
					fault_count++;
					$display("%0t: config_error expected %b got %b", $time,
						want.elem.config_error, result.config_error);
				end
			end
		end
	end

	// Any request, element or register write counts as progress.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (start && busy === 1'b0) || done !== 1'b0 || (cfg_valid && cfg_ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d elements outstanding", $time,
				STALL_LIMIT, pending_elems.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
design/im2col_pkg.sv
design/im2col_ram.sv
design/im2col_ctrl.sv
design/im2col_dp.sv
design/im2col_patch_generator_unit.sv
dv/im2col_patch_generator_unit_tb.sv
